// File: design/sfir_pkg.sv
// ----------------------------------------------------------------------------
// sfir_pkg
// Shared types and constants of the symmetric zero-phase FIR core.
// ----------------------------------------------------------------------------
package sfir_pkg;

	localparam int MAX_TAPS       = 16;
	localparam int SAMPLE_BITS    = 16;
	localparam int COEF_BITS      = 16;
	localparam int COEF_FRAC_BITS = 15;
	localparam int HIST_DEPTH     = 2 * MAX_TAPS - 1;
	localparam int TAP_IDX_W      = $clog2(MAX_TAPS);
	localparam int HIST_IDX_W     = $clog2(HIST_DEPTH);
	localparam int TAP_CNT_W      = 5;
	localparam int SEEN_W         = 5;
	localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
	localparam int ACC_BITS       = PROD_BITS + HIST_IDX_W;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 5;
	localparam int IN_DATA_W      = 56;
	localparam int OUT_DATA_W     = 32;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_COEF   = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE = 1'b1;

	typedef struct packed {
		logic                          op;
		logic [TAP_IDX_W-1:0]          coef_index;
		logic signed [COEF_BITS-1:0]   coef_value;
		logic signed [SAMPLE_BITS-1:0] left_sample;
		logic signed [SAMPLE_BITS-1:0] right_sample;
		logic                          last;
	} cmd_t;

endpackage

// File: design/sfir_front.sv
// ----------------------------------------------------------------------------
// sfir_front
// Accepts input transfers, unpacks them into commands and queues them.
// ----------------------------------------------------------------------------
module sfir_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// coef_index[3:0], coef_value[19:4], left_sample[35:20], right_sample[51:36]
	input  logic [sfir_pkg::IN_DATA_W-1:0] s_axis_tdata,
	// op
	input  logic                          s_axis_tuser,
	input  logic                          s_axis_tlast,
	output logic                          cmd_valid,
	input  logic                          cmd_ready,
	output sfir_pkg::cmd_t                cmd
);
	import sfir_pkg::*;

	cmd_t       queue_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;
	cmd_t       in_cmd;

	always_comb begin
		in_cmd.op           = s_axis_tuser;
		in_cmd.coef_index   = s_axis_tdata[3:0];
		in_cmd.coef_value   = s_axis_tdata[19:4];
		in_cmd.left_sample  = s_axis_tdata[35:20];
		in_cmd.right_sample = s_axis_tdata[51:36];
		in_cmd.last         = s_axis_tlast;
	end

	assign s_axis_tready = (count_q != 2'd2);
	assign push          = s_axis_tvalid && s_axis_tready;
	assign cmd_valid     = (count_q != 2'd0);
	assign pop           = cmd_valid && cmd_ready;
	assign cmd           = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// File: design/sfir_back.sv
// ----------------------------------------------------------------------------
// sfir_back
// Executes queued commands: coefficient loads, history shifts and the
// shared multiply-accumulate that forms each filtered output.
// ----------------------------------------------------------------------------
module sfir_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	output logic                            cmd_ready,
	input  sfir_pkg::cmd_t                  cmd,
	input  logic [sfir_pkg::TAP_CNT_W-1:0]  tap_count,
	input  logic                            stereo_mode,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [sfir_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic                            m_axis_tuser,
	output logic                            m_axis_tlast
);
	import sfir_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_MAC   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_OUT   = 4'b1000
	} state_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] val;
		logic                          clip;
	} sat_t;

	state_t                        state_q;
	logic signed [COEF_BITS-1:0]   coef_q [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] hist_l_q [HIST_DEPTH];
	logic signed [SAMPLE_BITS-1:0] hist_r_q [HIST_DEPTH];
	logic [SEEN_W-1:0]             seen_q;
	logic [TAP_IDX_W-1:0]          d_q;
	logic [HIST_IDX_W-1:0]         j_q;
	logic                          flush_q;
	logic signed [ACC_BITS-1:0]    acc_l_q;
	logic signed [ACC_BITS-1:0]    acc_r_q;
	logic signed [PROD_BITS-1:0]   prod_l_s1;
	logic signed [PROD_BITS-1:0]   prod_r_s1;
	logic                          prod_vld_s1;
	logic                          out_valid_q;
	logic [OUT_DATA_W-1:0]         out_data_q;
	logic                          out_clip_q;
	logic                          out_last_q;

	logic [TAP_IDX_W-1:0]          n_m1;
	logic [SEEN_W-1:0]             seen_new;
	logic [TAP_IDX_W-1:0]          dmax;
	logic signed [HIST_IDX_W+1:0]  tap_off;
	logic signed [HIST_IDX_W+1:0]  pos;
	logic [TAP_IDX_W-1:0]          k;
	logic                          pos_ok;
	logic signed [SAMPLE_BITS-1:0] x_l;
	logic signed [SAMPLE_BITS-1:0] x_r;
	logic                          out_free;
	sat_t                          sat_l;
	sat_t                          sat_r;

	function automatic sat_t round_sat(input logic signed [ACC_BITS-1:0] acc);
		logic signed [ACC_BITS:0]                sum;
		logic signed [ACC_BITS-COEF_FRAC_BITS:0] q;
		sat_t                                    r;
		sum = {acc[ACC_BITS-1], acc} + (ACC_BITS+1)'(1 << (COEF_FRAC_BITS - 1));
		q   = sum[ACC_BITS:COEF_FRAC_BITS];
		if (q > (ACC_BITS-COEF_FRAC_BITS+1)'((1 << (SAMPLE_BITS - 1)) - 1)) begin
			r.val  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			r.clip = 1'b1;
		end else if (q < -(ACC_BITS-COEF_FRAC_BITS+1)'(1 << (SAMPLE_BITS - 1))) begin
			r.val  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			r.clip = 1'b1;
		end else begin
			r.val  = q[SAMPLE_BITS-1:0];
			r.clip = 1'b0;
		end
		return r;
	endfunction

	always_comb begin
		if (tap_count == '0) begin
			n_m1 = '0;
		end else if (tap_count > TAP_CNT_W'(MAX_TAPS)) begin
			n_m1 = TAP_IDX_W'(MAX_TAPS - 1);
		end else begin
			n_m1 = TAP_IDX_W'(tap_count - 1'b1);
		end
		seen_new = (seen_q == '1) ? seen_q : seen_q + 1'b1;
		if ((seen_new - 1'b1) > SEEN_W'(n_m1)) begin
			dmax = n_m1;
		end else begin
			dmax = TAP_IDX_W'(seen_new - 1'b1);
		end
		tap_off = $signed({2'b00, j_q}) - $signed({3'b000, n_m1});
		pos     = $signed({3'b000, d_q}) - tap_off;
		k       = tap_off[HIST_IDX_W+1] ? TAP_IDX_W'(-tap_off) : TAP_IDX_W'(tap_off);
		pos_ok  = !pos[HIST_IDX_W+1] && (pos[HIST_IDX_W:0] < (HIST_IDX_W+1)'(HIST_DEPTH));
		x_l     = pos_ok ? hist_l_q[pos[HIST_IDX_W-1:0]] : '0;
		x_r     = pos_ok ? hist_r_q[pos[HIST_IDX_W-1:0]] : '0;
		sat_l   = round_sat(acc_l_q);
		sat_r   = round_sat(acc_r_q);
	end

	assign cmd_ready     = (state_q == ST_IDLE);
	assign out_free      = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_clip_q;
	assign m_axis_tlast  = out_last_q;

	always_ff @(posedge clk) begin
		prod_l_s1 <= coef_q[k] * x_l;
		prod_r_s1 <= coef_q[k] * x_r;
		if (state_q == ST_OUT && out_free) begin
			out_data_q <= {stereo_mode ? sat_r.val : SAMPLE_BITS'(0), sat_l.val};
			out_clip_q <= sat_l.clip || (stereo_mode && sat_r.clip);
			out_last_q <= flush_q && (d_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seen_q      <= '0;
			d_q         <= '0;
			j_q         <= '0;
			flush_q     <= 1'b0;
			acc_l_q     <= '0;
			acc_r_q     <= '0;
			prod_vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_TAPS; i++) begin
				coef_q[i] <= '0;
			end
			for (int i = 0; i < HIST_DEPTH; i++) begin
				hist_l_q[i] <= '0;
				hist_r_q[i] <= '0;
			end
		end else begin
			prod_vld_s1 <= (state_q == ST_MAC);
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					j_q     <= '0;
					acc_l_q <= '0;
					acc_r_q <= '0;
					if (cmd_valid) begin
						if (cmd.op == OP_COEF) begin
							coef_q[cmd.coef_index] <= cmd.coef_value;
						end else begin
							for (int i = HIST_DEPTH - 1; i > 0; i--) begin
								hist_l_q[i] <= hist_l_q[i-1];
								hist_r_q[i] <= hist_r_q[i-1];
							end
							hist_l_q[0] <= cmd.left_sample;
							hist_r_q[0] <= stereo_mode ? cmd.right_sample : '0;
							seen_q      <= seen_new;
							if (cmd.last) begin
								d_q     <= dmax;
								flush_q <= 1'b1;
								state_q <= ST_MAC;
							end else if (seen_new >= SEEN_W'(n_m1) + 1'b1) begin
								d_q     <= n_m1;
								flush_q <= 1'b0;
								state_q <= ST_MAC;
							end
						end
					end
				end
				ST_MAC: begin
					if (prod_vld_s1) begin
						acc_l_q <= acc_l_q + ACC_BITS'(prod_l_s1);
						acc_r_q <= acc_r_q + ACC_BITS'(prod_r_s1);
					end
					j_q <= j_q + 1'b1;
					if (j_q == {n_m1, 1'b0}) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					acc_l_q <= acc_l_q + ACC_BITS'(prod_l_s1);
					acc_r_q <= acc_r_q + ACC_BITS'(prod_r_s1);
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						j_q         <= '0;
						acc_l_q     <= '0;
						acc_r_q     <= '0;
						if (flush_q && d_q != '0) begin
							d_q     <= d_q - 1'b1;
							state_q <= ST_MAC;
						end else begin
							if (flush_q) begin
								seen_q <= '0;
								for (int i = 0; i < HIST_DEPTH; i++) begin
									hist_l_q[i] <= '0;
									hist_r_q[i] <= '0;
								end
							end
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: design/symmetric_zero_phase_fir_core.sv
// ----------------------------------------------------------------------------
// symmetric_zero_phase_fir_core
// Centered symmetric FIR over a mono or stereo sample stream.
// ----------------------------------------------------------------------------
// Channel   Direction  Carries
// s_axis    in         sample or coefficient load, tlast ends a stream
// m_axis    out        filtered left/right sample, tuser is the clip flag
// cfg       in         tap_count (index 0), stereo_mode (index 1)
//
// An output is formed from its command on the shared multiply-accumulate
// of each lane; a flush gives up to N outputs in a row, where N is the
// active tap count. A coefficient load or a sample that yields no output
// does not enter the multiply-accumulate. A two-entry command queue lets
// the input side keep accepting while the back end computes, until it is
// full, and the output register holds a result under stall.
// Reset clears coefficients, history and control state at once.
// ----------------------------------------------------------------------------
module symmetric_zero_phase_fir_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sfir_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sfir_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// coef_index[3:0], coef_value[19:4], left_sample[35:20], right_sample[51:36]
	input  logic [sfir_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// op
	input  logic                             s_axis_tuser,
	input  logic                             s_axis_tlast,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// left_out[15:0], right_out[31:16]
	output logic [sfir_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// clipped
	output logic                             m_axis_tuser,
	output logic                             m_axis_tlast
);
	import sfir_pkg::*;

	logic [TAP_CNT_W-1:0] tap_count_q;
	logic                 stereo_mode_q;
	logic                 cmd_valid;
	logic                 cmd_ready;
	cmd_t                 cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q   <= TAP_CNT_W'(1);
			stereo_mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TAP_COUNT:   tap_count_q   <= cfg_data[TAP_CNT_W-1:0];
				REG_STEREO_MODE: stereo_mode_q <= cfg_data[0];
				default:         ;
			endcase
		end
	end

	sfir_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready),
		.cmd           (cmd)
	);

	sfir_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_ready     (cmd_ready),
		.cmd           (cmd),
		.tap_count     (tap_count_q),
		.stereo_mode   (stereo_mode_q),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// File: design/sfir_checker.sv
// ----------------------------------------------------------------------------
// sfir_checker
// Port-level checks of the symmetric zero-phase FIR core.
// ----------------------------------------------------------------------------
module sfir_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             cfg_we,
	input logic [sfir_pkg::CFG_IDX_W-1:0]   cfg_index,
	input logic [sfir_pkg::CFG_DATA_W-1:0]  cfg_data,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic [sfir_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	input logic                             s_axis_tuser,
	input logic                             s_axis_tlast,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [sfir_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input logic                             m_axis_tuser,
	input logic                             m_axis_tlast
);
	import sfir_pkg::*;

	logic stereo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stereo_q <= 1'b0;
		end else if (cfg_we && cfg_index == REG_STEREO_MODE) begin
			stereo_q <= cfg_data[0];
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid &&
			$stable({m_axis_tdata, m_axis_tuser, m_axis_tlast}))
		else $error("output changed while stalled");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid &&
			$stable({s_axis_tdata, s_axis_tuser, s_axis_tlast}))
		else $error("input changed while waiting");

	a_mono_right_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !stereo_q |-> m_axis_tdata[31:16] == 16'd0)
		else $error("right lane nonzero in mono mode");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !m_axis_tvalid)
		else $error("output valid right after reset");

endmodule

bind symmetric_zero_phase_fir_core sfir_checker u_sfir_checker (.*);

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// Testbench for symmetric_zero_phase_fir_core
// Streams coefficient loads and mono and stereo sample runs into the core
// under random sender bursts and receiver stalls. A scoreboard keeps its own
// copy of the filter state, predicts every filtered output and checks each
// output transfer against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sfir_pkg::*;

	typedef struct {
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic               last;
		logic               clip;
	} fir_out_t;

	class fir_scoreboard;
		fir_out_t         pending_q[$];
		int               errors;
		int               tap_cfg;
		bit               stereo;
		longint           coefs[MAX_TAPS];
		longint           hist_l[HIST_DEPTH];
		longint           hist_r[HIST_DEPTH];
		int               seen;

		function new();
			errors = 0;
			tap_cfg = 1;
			stereo = 0;
			seen = 0;
			foreach (coefs[k]) coefs[k] = 0;
			clear_history();
		endfunction

		function void clear_history();
			foreach (hist_l[k]) begin
				hist_l[k] = 0;
				hist_r[k] = 0;
			end
		endfunction

		function logic signed [15:0] filter_lane(bit right_lane, int n, int d, inout bit clip);
			longint acc;
			longint q;
			int     pos;
			acc = 0;
			for (int t = -(n - 1); t <= n - 1; t++) begin
				pos = d - t;
				if (pos >= 0 && pos < HIST_DEPTH)
					acc += coefs[t < 0 ? -t : t] * (right_lane ? hist_r[pos] : hist_l[pos]);
			end
			q = (acc + (64'sd1 <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
			if (q > 32767) begin
				q = 32767;
				clip = 1;
			end
			if (q < -32768) begin
				q = -32768;
				clip = 1;
			end
			return q[15:0];
		endfunction

		function void add_output(int n, int d, bit lst);
			fir_out_t o;
			bit       clip;
			clip = 0;
			o.left = filter_lane(0, n, d, clip);
			o.right = stereo ? filter_lane(1, n, d, clip) : 16'sd0;
			o.last = lst;
			o.clip = clip;
			pending_q.push_back(o);
		endfunction

		function void note_input(logic op, logic [3:0] idx, logic signed [15:0] cv,
				logic signed [15:0] ls, logic signed [15:0] rs, logic lst);
			int n;
			int dmax;
			n = tap_cfg == 0 ? 1 : (tap_cfg > MAX_TAPS ? MAX_TAPS : tap_cfg);
			if (op == OP_COEF) begin
				coefs[idx] = cv;
				return;
			end
			for (int k = HIST_DEPTH - 1; k > 0; k--) begin
				hist_l[k] = hist_l[k - 1];
				hist_r[k] = hist_r[k - 1];
			end
			hist_l[0] = ls;
			hist_r[0] = stereo ? longint'(rs) : 0;
			if (seen < 31) seen++;
			if (lst) begin
				dmax = seen - 1 > n - 1 ? n - 1 : seen - 1;
				for (int d = dmax; d >= 0; d--) add_output(n, d, d == 0);
				clear_history();
				seen = 0;
			end else if (seen >= n) begin
				add_output(n, n - 1, 0);
			end
		endfunction

		function void check(logic [31:0] data, logic clip, logic lst);
			fir_out_t e;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected output left %0d right %0d", $time,
					$signed(data[15:0]), $signed(data[31:16]));
				errors++;
				return;
			end
			e = pending_q.pop_front();
			if (data[15:0] !== e.left) begin
				$display("%0t: left_out expected %0d actual %0d", $time, e.left,
					$signed(data[15:0]));
				errors++;
			end
			if (data[31:16] !== e.right) begin
				$display("%0t: right_out expected %0d actual %0d", $time, e.right,
					$signed(data[31:16]));
				errors++;
			end
			if (lst !== e.last) begin
				$display("%0t: last_out expected %0b actual %0b", $time, e.last, lst);
				errors++;
			end
			if (clip !== e.clip) begin
				$display("%0t: clipped expected %0b actual %0b", $time, e.clip, clip);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  s_axis_tlast;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  m_axis_tlast;

	fir_scoreboard sb = new();
	int            burst_left;
	int            idle_cycles;
	int            stall_mode;
	int            cycle_count;

	symmetric_zero_phase_fir_core i_dut (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check(m_axis_tdata, m_axis_tuser, m_axis_tlast);
	end

	// Receiver stall pattern: one of four randomly chosen modes of m_axis_tready.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count % 300 == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= $urandom_range(0, 3) != 0;
			2: m_axis_tready <= 1'($urandom_range(0, 1));
			default: m_axis_tready <= (cycle_count % 7) < 2;
		endcase
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic send(logic op, logic [3:0] idx, logic [15:0] cv, logic [15:0] ls,
			logic [15:0] rs, logic lst);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tlast <= lst;
		s_axis_tdata <= {4'd0, rs, ls, cv, idx};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(op, idx, cv, ls, rs, lst);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic configure(int taps, bit st);
		cfg_we <= 1'b1;
		cfg_index <= REG_TAP_COUNT;
		cfg_data <= taps[4:0];
		@(posedge clk);
		cfg_index <= REG_STEREO_MODE;
		cfg_data <= {4'd0, st};
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.tap_cfg = taps;
		sb.stereo = st;
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 16'h7fff;
			1: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_stream(int len);
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(0, 15) == 0)
				send(OP_COEF, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					1'($urandom));
			send(OP_SAMPLE, 4'($urandom), 16'($urandom), pick_sample(), pick_sample(),
				k == len - 1);
		end
	endtask

	initial begin
		int taps;
		int len;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = 0;
		s_axis_tlast = 0;
		m_axis_tready = 0;
		burst_left = 0;
		idle_cycles = 0;
		stall_mode = 0;
		cycle_count = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed part: extremes, ignored last on loads, short stream flush.
		configure(3, 1);
		send(OP_COEF, 4'd0, 16'h7fff, 16'h0, 16'h0, 1'b1);
		send(OP_COEF, 4'd1, 16'h8000, 16'hffff, 16'hffff, 1'b0);
		send(OP_COEF, 4'd2, 16'h4000, 16'h0, 16'h0, 1'b0);
		send(OP_COEF, 4'd15, 16'h7fff, 16'h0, 16'h0, 1'b0);
		send(OP_SAMPLE, 4'd0, 16'h0, 16'h7fff, 16'h8000, 1'b0);
		send(OP_SAMPLE, 4'd0, 16'h0, 16'h8000, 16'h7fff, 1'b0);
		send(OP_SAMPLE, 4'd0, 16'h0, 16'h7fff, 16'h8000, 1'b0);
		send(OP_SAMPLE, 4'd0, 16'h0, 16'h8000, 16'h7fff, 1'b1);
		send(OP_SAMPLE, 4'd0, 16'h0, 16'h1234, 16'h8000, 1'b1);
		send(OP_SAMPLE, 4'd0, 16'h0, 16'h8000, 16'h0001, 1'b0);
		send(OP_SAMPLE, 4'd0, 16'h0, 16'h7fff, 16'hffff, 1'b1);
		drain();
		configure(0, 0);
		send(OP_SAMPLE, 4'd0, 16'h0, 16'h8000, 16'h7fff, 1'b0);
		send(OP_SAMPLE, 4'd0, 16'h0, 16'h7fff, 16'h7fff, 1'b1);
		drain();
		configure(31, 1);
		for (int k = 0; k < MAX_TAPS; k++)
			send(OP_COEF, 4'(k), k[0] ? 16'h8000 : 16'h7fff, 16'h0, 16'h0, 1'b0);
		random_stream(4);
		drain();

		// Random phases: the first four set the tap count, the rest pick it at random.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: taps = 16;
				1: taps = 1;
				2: taps = 0;
				3: taps = 31;
				default: taps = $urandom_range(0, 31);
			endcase
			configure(taps, ph == 1 ? 0 : (ph == 3 ? 1 : $urandom_range(0, 1)));
			for (int k = 0; k < MAX_TAPS; k++)
				if ($urandom_range(0, 3) == 0)
					send(OP_COEF, 4'(k), $urandom_range(0, 3) == 0 ? pick_sample()
						: 16'($urandom_range(0, 8191) - 4096), 16'($urandom),
						16'($urandom), 1'($urandom));
			len = ph == 0 ? 31 : $urandom_range(1, 8);
			random_stream(len);
			random_stream($urandom_range(1, 8));
			drain();
		end

		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
